[rtl/mrrc_pkg.sv]
package mrrc_pkg;

    // Frame geometry and CRC constants.
    localparam int unsigned MaxFrame   = 256;
    localparam int unsigned LenWidth   = 9;
    localparam logic [15:0] CrcInit    = 16'hFFFF;
    localparam logic [15:0] CrcPoly    = 16'hA001;
    localparam logic [8:0]  IdleLength = 9'd5;
    localparam logic [8:0]  HeaderLen  = 9'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SLAVE_ADDRESS  = 2'd0;
    localparam logic [1:0] CFG_FUNCTION_CODE  = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_COUNT = 2'd2;

    // End-of-frame status codes.
    typedef enum logic [2:0] {
        ST_GOOD      = 3'd0,
        ST_CRC       = 3'd1,
        ST_ADDRESS   = 3'd2,
        ST_FUNCTION  = 3'd3,
        ST_COUNT     = 3'd4,
        ST_EXCEPTION = 3'd5,
        ST_TIMEOUT   = 3'd6,
        ST_TOO_LONG  = 3'd7
    } t_status;

    // Result word kinds.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One result word.
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        t_status    status;
        logic [7:0] exception_code;
    } t_result;

    // CRC-16 update for one byte, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/mrrc_out_skid.sv]
module mrrc_out_skid import mrrc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_word,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_word
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    take;

    assign take    = r_main_valid && i_ready;
    assign o_valid = r_main_valid;
    assign o_word  = r_main;
    assign o_full  = r_skid_valid;

    // Control: the skid entry holds a word that arrived while the output was stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || take) begin
            r_main_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge i_clk) begin
        if (!r_main_valid || take) begin
            r_main <= r_skid_valid ? r_skid : i_word;
        end else if (i_push) begin
            r_skid <= i_word;
        end
    end

endmodule

[rtl/modbus_rtu_response_checker_core.sv]
// A result word is registered in the output buffer before it is presented.
// One byte is accepted per cycle while input ready is high; the CRC update for a byte is combinational.
// A two-entry output buffer lowers input ready only while two result words are waiting.
// Reset (synchronous, active low) closes any open frame, empties the output buffer
// and loads the configuration defaults: address 1, function 3, byte count 2.
module modbus_rtu_response_checker_core import mrrc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    input  logic       i_gap,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_byte_index,
    output logic [2:0] o_status,
    output logic [7:0] o_exception_code
);

    // Configuration registers.
    logic [7:0] r_slave_address;
    logic [6:0] r_function_code;
    logic [7:0] r_expected_count;

    // Frame state.
    logic [15:0]         r_crc, n_crc;
    logic [LenWidth-1:0] r_cnt, n_cnt;
    logic [LenWidth-1:0] r_len, n_len;
    logic                r_in_frame, n_in_frame;
    t_status             r_herr, n_herr;
    logic [7:0]          r_crc_low, n_crc_low;
    logic                r_exc, n_exc;
    logic [7:0]          r_held_exc, n_held_exc;

    // Working copies after an optional restart.
    logic [15:0]         c_crc;
    logic [LenWidth-1:0] c_cnt;
    logic [LenWidth-1:0] c_len;
    t_status             c_herr;
    logic                c_exc;
    logic [LenWidth:0]   p_plus2;
    logic [LenWidth:0]   len_need;
    logic [15:0]         got_crc;

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_word;
    logic    buf_full;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !buf_full;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address  <= 8'd1;
            r_function_code  <= 7'd3;
            r_expected_count <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLAVE_ADDRESS:  r_slave_address  <= i_cfg_data;
                CFG_FUNCTION_CODE:  r_function_code  <= i_cfg_data[6:0];
                CFG_EXPECTED_COUNT: r_expected_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Per-byte frame checking.
    always_comb begin
        n_crc      = r_crc;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_in_frame = r_in_frame;
        n_herr     = r_herr;
        n_crc_low  = r_crc_low;
        n_exc      = r_exc;
        n_held_exc = r_held_exc;
        res_valid  = 1'b0;
        res        = '0;
        c_crc      = r_crc;
        c_cnt      = r_cnt;
        c_len      = r_len;
        c_herr     = r_herr;
        c_exc      = r_exc;
        p_plus2    = '0;
        len_need   = '0;
        got_crc    = {i_rx_byte, r_crc_low};

        if (accept) begin
            if (i_gap) begin
                // Silence ends an open frame with a timeout.
                if (r_in_frame) begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_STATUS;
                    res.byte_index = r_cnt[7:0];
                    res.status     = ST_TIMEOUT;
                    n_crc      = CrcInit;
                    n_cnt      = '0;
                    n_len      = IdleLength;
                    n_in_frame = 1'b0;
                    n_herr     = ST_GOOD;
                    n_crc_low  = '0;
                    n_exc      = 1'b0;
                    n_held_exc = '0;
                end
            end else if (i_frame_start || r_in_frame) begin
                // A start byte inside an open frame reports that frame as timed out.
                if (i_frame_start) begin
                    if (r_in_frame) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_STATUS;
                        res.byte_index = r_cnt[7:0];
                        res.status     = ST_TIMEOUT;
                    end
                    c_crc      = CrcInit;
                    c_cnt      = '0;
                    c_len      = IdleLength;
                    c_herr     = ST_GOOD;
                    c_exc      = 1'b0;
                    n_crc_low  = '0;
                    n_held_exc = '0;
                end
                n_in_frame = 1'b1;
                n_crc      = c_crc;
                n_len      = c_len;
                n_herr     = c_herr;
                n_exc      = c_exc;
                n_cnt      = c_cnt + 1'b1;
                p_plus2    = {1'b0, c_cnt} + (LenWidth+1)'(2);

                if (p_plus2 < {1'b0, c_len}) begin
                    // Header and payload bytes go into the CRC.
                    n_crc = crc_byte(c_crc, i_rx_byte);
                    if (c_cnt == '0) begin
                        if (i_rx_byte != r_slave_address) begin
                            n_herr = ST_ADDRESS;
                        end
                    end else if (c_cnt == LenWidth'(1)) begin
                        n_exc = i_rx_byte[7];
                        if (i_rx_byte[6:0] != r_function_code && c_herr == ST_GOOD) begin
                            n_herr = ST_FUNCTION;
                        end
                    end else if (c_cnt == LenWidth'(2)) begin
                        if (c_exc) begin
                            n_held_exc = i_rx_byte;
                        end else begin
                            if (i_rx_byte != r_expected_count && c_herr == ST_GOOD) begin
                                n_herr = ST_COUNT;
                            end
                            len_need = (LenWidth+1)'(i_rx_byte) + (LenWidth+1)'(5);
                            if (len_need > (LenWidth+1)'(MaxFrame)) begin
                                // The announced length cannot fit: report and drop the frame.
                                res_valid      = 1'b1;
                                res.kind       = KIND_STATUS;
                                res.byte_index = HeaderLen[7:0];
                                res.status     = ST_TOO_LONG;
                                n_crc      = CrcInit;
                                n_cnt      = '0;
                                n_len      = IdleLength;
                                n_in_frame = 1'b0;
                                n_herr     = ST_GOOD;
                                n_crc_low  = '0;
                                n_exc      = 1'b0;
                                n_held_exc = '0;
                            end else begin
                                n_len = len_need[LenWidth-1:0];
                            end
                        end
                    end else begin
                        // Payload byte is forwarded with its position.
                        res_valid      = 1'b1;
                        res.kind       = KIND_DATA;
                        res.data_byte  = i_rx_byte;
                        res.byte_index = 8'(c_cnt - HeaderLen);
                        res.status     = ST_GOOD;
                    end
                end else if (p_plus2 == {1'b0, c_len}) begin
                    n_crc_low = i_rx_byte;
                end else begin
                    // Last byte: compare the CRC and give the frame status.
                    res_valid      = 1'b1;
                    res.kind       = KIND_STATUS;
                    res.byte_index = 8'(c_cnt + 1'b1);
                    if (got_crc != c_crc) begin
                        res.status = ST_CRC;
                    end else if (c_herr != ST_GOOD) begin
                        res.status = c_herr;
                    end else if (c_exc) begin
                        res.status         = ST_EXCEPTION;
                        res.exception_code = r_held_exc;
                    end else begin
                        res.status = ST_GOOD;
                    end
                    n_crc      = CrcInit;
                    n_cnt      = '0;
                    n_len      = IdleLength;
                    n_in_frame = 1'b0;
                    n_herr     = ST_GOOD;
                    n_crc_low  = '0;
                    n_exc      = 1'b0;
                    n_held_exc = '0;
                end
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= CrcInit;
            r_cnt      <= '0;
            r_len      <= IdleLength;
            r_in_frame <= 1'b0;
            r_herr     <= ST_GOOD;
            r_crc_low  <= '0;
            r_exc      <= 1'b0;
            r_held_exc <= '0;
        end else begin
            r_crc      <= n_crc;
            r_cnt      <= n_cnt;
            r_len      <= n_len;
            r_in_frame <= n_in_frame;
            r_herr     <= n_herr;
            r_crc_low  <= n_crc_low;
            r_exc      <= n_exc;
            r_held_exc <= n_held_exc;
        end
    end

    // Result buffer between the checker and the output channel.
    mrrc_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_word  (res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (out_word)
    );

    assign o_kind           = out_word.kind;
    assign o_data_byte      = out_word.data_byte;
    assign o_byte_index     = out_word.byte_index;
    assign o_status         = out_word.status;
    assign o_exception_code = out_word.exception_code;

endmodule

[dv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrrc_pkg::*;

    localparam int          LONG_HOLD  = 300;
    localparam int          SETTLE     = 6;
    localparam int          NUM_PHASES = 7;
    localparam logic [7:0]  EXC_FLAG   = 8'h80;

    // Ways a random frame can be spoiled.
    typedef enum int {
        FLT_NONE,
        FLT_ADDRESS,
        FLT_EXCEPTION,
        FLT_FUNCTION,
        FLT_COUNT,
        FLT_TOO_LONG,
        FLT_FULL_LENGTH,
        FLT_CRC,
        FLT_CUT
    } t_fault;

    // Output stall patterns.
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    // One row of the directed table.
    typedef struct {
        logic [7:0] b;
        logic       s;
        logic       g;
        bit         typed;
        bit         typed_got;
        t_result    w;
    } t_row;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic [1:0] i_cfg_index   = CFG_SLAVE_ADDRESS;
    logic [7:0] i_cfg_data    = 8'h00;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_rx_byte     = 8'h00;
    logic       i_frame_start = 1'b0;
    logic       i_gap         = 1'b0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_kind;
    logic [7:0] o_data_byte;
    logic [7:0] o_byte_index;
    logic [2:0] o_status;
    logic [7:0] o_exception_code;

    // Copy of the configuration registers.
    logic [7:0] cfg_addr;
    logic [6:0] cfg_func;
    logic [7:0] cfg_count;

    // Frame tracking state of the checker.
    logic [15:0] m_crc;
    logic [8:0]  m_count;
    logic [8:0]  m_len;
    logic        m_open;
    t_status     m_hdr_err;
    logic [7:0]  m_crc_lo;
    logic        m_exc;
    logic [7:0]  m_exc_code;

    t_result queued_reports[$];
    t_row    rows[$];

    int  error_count     = 0;
    int  reports_checked = 0;
    int  words_sent      = 0;
    int  frames_sent     = 0;
    int  noise_sent      = 0;
    int  burst_left      = 0;
    bit  long_hold_req   = 1'b0;

    modbus_rtu_response_checker_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_frame_start    (i_frame_start),
        .i_gap            (i_gap),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_byte_index     (o_byte_index),
        .o_status         (o_status),
        .o_exception_code (o_exception_code)
    );

    always #5 i_clk = ~i_clk;

    // CRC-16 step, one data bit at a time entering at the low end.
    function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ data[i];
            r  = {1'b0, r[15:1]};
            if (fb) begin
                r = r ^ CrcPoly;
            end
        end
        return r;
    endfunction

    function automatic t_result status_report(input logic [7:0] idx, input t_status st,
                                              input logic [7:0] exc);
        t_result r;
        r.kind           = KIND_STATUS;
        r.data_byte      = 8'h00;
        r.byte_index     = idx;
        r.status         = st;
        r.exception_code = exc;
        return r;
    endfunction

    // Return the frame tracker to its idle state.
    task automatic close_frame();
        m_crc      = CrcInit;
        m_count    = '0;
        m_len      = IdleLength;
        m_open     = 1'b0;
        m_hdr_err  = ST_GOOD;
        m_crc_lo   = 8'h00;
        m_exc      = 1'b0;
        m_exc_code = 8'h00;
    endtask

    // Work out the report, if any, that one accepted word causes.
    task automatic compute_report(input logic [7:0] b, input logic s, input logic g,
                                  output bit got, output t_result rep);
        int unsigned p;
        t_status     st;
        logic [7:0]  exc;
        got = 1'b0;
        rep = '0;
        if (g) begin
            // A silence gap closes an open frame as a timeout.
            if (m_open) begin
                got = 1'b1;
                rep = status_report(m_count[7:0], ST_TIMEOUT, 8'h00);
                close_frame();
            end
        end else if (s || m_open) begin
            // A start inside an open frame reports the partial frame first.
            if (s) begin
                if (m_open) begin
                    got = 1'b1;
                    rep = status_report(m_count[7:0], ST_TIMEOUT, 8'h00);
                end
                close_frame();
                m_open = 1'b1;
            end
            p       = m_count;
            m_count = m_count + 9'd1;
            if (p + 2 < m_len) begin
                m_crc = crc16_next(m_crc, b);
                case (p)
                    0: begin
                        if (b != cfg_addr) begin
                            m_hdr_err = ST_ADDRESS;
                        end
                    end
                    1: begin
                        m_exc = b[7];
                        if (b[6:0] != cfg_func && m_hdr_err == ST_GOOD) begin
                            m_hdr_err = ST_FUNCTION;
                        end
                    end
                    2: begin
                        if (m_exc) begin
                            m_exc_code = b;
                        end else begin
                            if (b != cfg_count && m_hdr_err == ST_GOOD) begin
                                m_hdr_err = ST_COUNT;
                            end
                            if (32'(b) + 32'(IdleLength) > MaxFrame) begin
                                got = 1'b1;
                                rep = status_report(HeaderLen[7:0], ST_TOO_LONG, 8'h00);
                                close_frame();
                            end else begin
                                m_len = IdleLength + 9'(b);
                            end
                        end
                    end
                    default: begin
                        got = 1'b1;
                        rep = t_result'{KIND_DATA, b, 8'(p - 3), ST_GOOD, 8'h00};
                    end
                endcase
            end else if (p + 2 == m_len) begin
                m_crc_lo = b;
            end else begin
                // Last byte: CRC first, then header errors, then exception.
                exc = 8'h00;
                if ({b, m_crc_lo} != m_crc) begin
                    st = ST_CRC;
                end else if (m_hdr_err != ST_GOOD) begin
                    st = m_hdr_err;
                end else if (m_exc) begin
                    st  = ST_EXCEPTION;
                    exc = m_exc_code;
                end else begin
                    st = ST_GOOD;
                end
                got = 1'b1;
                rep = status_report(8'(p + 1), st, exc);
                close_frame();
            end
        end
    endtask

    // Offer one word and wait until it is taken.
    task automatic offer_word(input logic [7:0] b, input logic s, input logic g,
                              output bit got, output t_result rep);
        i_in_valid    <= 1'b1;
        i_rx_byte     <= b;
        i_frame_start <= s;
        i_gap         <= g;
        do @(posedge i_clk); while (!o_in_ready);
        compute_report(b, s, g, got, rep);
        words_sent++;
    endtask

    task automatic send_word(input logic [7:0] b, input logic s, input logic g);
        bit      got;
        t_result rep;
        offer_word(b, s, g, got, rep);
        if (got) begin
            queued_reports.push_back(rep);
        end
    endtask

    task automatic hold_valid_low(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Sender works in bursts with idle gaps in between.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            hold_valid_low(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 4));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Stop sending until every expected report has come out.
    task automatic wait_for_reports();
        i_in_valid <= 1'b0;
        while (queued_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write all three registers on back-to-back cycles.
    task automatic configure(input logic [7:0] addr, input logic [6:0] func,
                             input logic [7:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SLAVE_ADDRESS;
        i_cfg_data  <= addr;
        @(posedge i_clk);
        i_cfg_index <= CFG_FUNCTION_CODE;
        i_cfg_data  <= {1'b0, func};
        @(posedge i_clk);
        i_cfg_index <= CFG_EXPECTED_COUNT;
        i_cfg_data  <= count;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_addr  = addr;
        cfg_func  = func;
        cfg_count = count;
    endtask

    function automatic t_fault pick_fault();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return FLT_NONE;
        if (r < 55) return FLT_ADDRESS;
        if (r < 65) return FLT_EXCEPTION;
        if (r < 72) return FLT_FUNCTION;
        if (r < 79) return FLT_COUNT;
        if (r < 82) return FLT_TOO_LONG;
        if (r < 83) return FLT_FULL_LENGTH;
        if (r < 91) return FLT_CRC;
        return FLT_CUT;
    endfunction

    // Build a response frame around the current settings, maybe spoiled, and send it.
    task automatic send_random_frame();
        logic [7:0]  fb[$];
        logic [7:0]  func;
        logic [15:0] crc;
        t_fault      fault;
        int          count;
        int          cut;
        fault = pick_fault();
        func  = {1'b0, cfg_func};
        count = cfg_count;
        if (fault == FLT_FUNCTION) begin
            func = {1'b0, 7'($urandom_range(0, 127))};
        end
        if (fault == FLT_EXCEPTION) begin
            if ($urandom_range(0, 3) == 0) begin
                func = {1'b0, 7'($urandom_range(0, 127))};
            end
            func = func | EXC_FLAG;
        end
        if (fault == FLT_COUNT) begin
            count = $urandom_range(0, 12);
        end else if (fault == FLT_TOO_LONG) begin
            count = $urandom_range(MaxFrame - 4, 255);
        end else if (fault == FLT_FULL_LENGTH) begin
            count = MaxFrame - 5;
        end
        fb.push_back((fault == FLT_ADDRESS) ? 8'($urandom) : cfg_addr);
        fb.push_back(func);
        if (fault == FLT_EXCEPTION) begin
            fb.push_back(8'($urandom));
        end else begin
            fb.push_back(8'(count));
            if (fault != FLT_TOO_LONG) begin
                for (int i = 0; i < count; i++) begin
                    fb.push_back(8'($urandom));
                end
            end
        end
        if (fault != FLT_TOO_LONG) begin
            crc = CrcInit;
            foreach (fb[i]) begin
                crc = crc16_next(crc, fb[i]);
            end
            fb.push_back(crc[7:0]);
            fb.push_back(crc[15:8]);
        end
        if (fault == FLT_CRC) begin
            cut = fb.size() - 1 - $urandom_range(0, 1);
            fb[cut] = fb[cut] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (fault == FLT_CUT) begin
            cut = $urandom_range(1, fb.size() - 1);
            while (fb.size() > cut) void'(fb.pop_back());
        end
        foreach (fb[i]) begin
            send_word(fb[i], i == 0, 1'b0);
            pace_sender();
        end
        // A cut frame is ended by silence or left for the next start.
        if (fault == FLT_CUT && $urandom_range(0, 1) == 1) begin
            send_word(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
            pace_sender();
        end
        frames_sent++;
    endtask

    // Stray bytes, lone starts and gaps with any content.
    task automatic send_noise_word();
        send_word(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);
        pace_sender();
        noise_sent++;
    endtask

    task automatic add_row(input logic [7:0] b, input logic s, input logic g,
                           input bit typed, input bit typed_got, input t_result w);
        t_row r;
        r.b         = b;
        r.s         = s;
        r.g         = g;
        r.typed     = typed;
        r.typed_got = typed_got;
        r.w         = w;
        rows.push_back(r);
    endtask

    // Run limit.
    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    // Output side stalls on patterns of its own, with one long hold on request.
    initial begin : receiver
        t_rx_mode mode;
        int       mode_left;
        int       tick;
        mode      = RX_OPEN;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   i_out_ready <= 1'b1;
                    RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_out_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // Compare every accepted report with the oldest one expected.
    always @(posedge i_clk) begin : report_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (queued_reports.size() == 0) begin
                $error("unexpected report: kind %0d index %0d status %0d",
                       o_kind, o_byte_index, o_status);
                error_count++;
            end else begin
                want = queued_reports.pop_front();
                reports_checked++;
                if (o_kind !== want.kind) begin
                    $error("kind mismatch: expected %0d, got %0d", want.kind, o_kind);
                    error_count++;
                end
                if (o_data_byte !== want.data_byte) begin
                    $error("data_byte mismatch: expected %0h, got %0h",
                           want.data_byte, o_data_byte);
                    error_count++;
                end
                if (o_byte_index !== want.byte_index) begin
                    $error("byte_index mismatch: expected %0d, got %0d",
                           want.byte_index, o_byte_index);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_exception_code !== want.exception_code) begin
                    $error("exception_code mismatch: expected %0h, got %0h",
                           want.exception_code, o_exception_code);
                    error_count++;
                end
            end
        end
    end

    // Main stimulus.
    initial begin : stimulus
        bit          got;
        t_result     rep;
        logic [15:0] crc;
        int          target;

        // Hold reset, then start from the reset settings.
        repeat (4) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        cfg_addr  = 8'd1;
        cfg_func  = 7'd3;
        cfg_count = 8'd2;
        close_frame();

        // Idle: a gap does nothing.
        add_row(8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, '0);
        // A byte count over the frame limit ends the frame at the count byte.
        add_row(8'h01, 1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h03, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, 1'b1, 1'b1,
                status_report(HeaderLen[7:0], ST_TOO_LONG, 8'h00));
        // A stray byte with no frame open is dropped.
        add_row(8'h55, 1'b0, 1'b0, 1'b1, 1'b0, '0);
        // Good frame with payload bytes at both extremes.
        crc = crc16_next(crc16_next(crc16_next(crc16_next(crc16_next(
                  CrcInit, 8'h01), 8'h03), 8'h02), 8'h00), 8'hFF);
        add_row(8'h01, 1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h03, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h02, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b1, 1'b1,
                t_result'{KIND_DATA, 8'h00, 8'd0, ST_GOOD, 8'h00});
        add_row(8'hFF, 1'b0, 1'b0, 1'b1, 1'b1,
                t_result'{KIND_DATA, 8'hFF, 8'd1, ST_GOOD, 8'h00});
        add_row(crc[7:0], 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(crc[15:8], 1'b0, 1'b0, 1'b1, 1'b1, status_report(8'd7, ST_GOOD, 8'h00));
        // Exception reply: five bytes, the third one is the exception code.
        crc = crc16_next(crc16_next(crc16_next(CrcInit, 8'h01), 8'h83), 8'h02);
        add_row(8'h01, 1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h83, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h02, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(crc[7:0], 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(crc[15:8], 1'b0, 1'b0, 1'b1, 1'b1,
                status_report(8'd5, ST_EXCEPTION, 8'h02));
        // Silence in the middle of a frame.
        add_row(8'h01, 1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h03, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hA5, 1'b0, 1'b1, 1'b1, 1'b1, status_report(8'd2, ST_TIMEOUT, 8'h00));
        // A start inside a frame, then a gap that wins over a start.
        add_row(8'h01, 1'b1, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h02, 1'b1, 1'b0, 1'b1, 1'b1, status_report(8'd1, ST_TIMEOUT, 8'h00));
        add_row(8'hA5, 1'b1, 1'b1, 1'b1, 1'b1, status_report(8'd1, ST_TIMEOUT, 8'h00));
        add_row(8'h5A, 1'b1, 1'b1, 1'b1, 1'b0, '0);

        // Walk the directed table.
        foreach (rows[i]) begin
            offer_word(rows[i].b, rows[i].s, rows[i].g, got, rep);
            if (rows[i].typed) begin
                got = rows[i].typed_got;
                rep = rows[i].w;
            end
            if (got) begin
                queued_reports.push_back(rep);
            end
            pace_sender();
        end
        wait_for_reports();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: ;
                1: configure(8'h00, 7'd1, 8'd0);
                2: configure(8'hFF, 7'd127, 8'd250);
                default: configure(8'($urandom), 7'($urandom_range(1, 127)),
                                   8'($urandom_range(0, 6)));
            endcase
            // Hold the output off for a long stretch while words keep coming.
            if (ph == 3) begin
                long_hold_req = 1'b1;
            end
            target = words_sent + ((ph == 2) ? 450 : 200);
            while (words_sent < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_noise_word();
                end else begin
                    send_random_frame();
                end
            end
            // Close any open frame and let the block go quiet.
            send_word(8'h00, 1'b0, 1'b1);
            wait_for_reports();
        end

        $display("Run covered %0d words: %0d frames and %0d noise words over %0d settings,",
                 words_sent, frames_sent, noise_sent, NUM_PHASES);
        $display("with %0d reports checked against the frame tracker.", reports_checked);
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/mrrc_pkg.sv
rtl/mrrc_out_skid.sv
rtl/modbus_rtu_response_checker_core.sv
dv/tb_top.sv
